/* hw/rtl/shc_pkg.sv */
// Shared constants and codes for the staged heater controller.
package shc_pkg;

    localparam int NUM_STAGES   = 4;
    localparam int LANE_WIDTH   = 16;
    localparam int DELAY_WIDTH  = 16;
    localparam int FAULT_WIDTH  = 3;
    localparam int CFG_WIDTH    = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int SAFETY_LIMIT = 5000;
    localparam int FAULT_LIMIT  = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM_ENABLES = 3'd0,
        CFG_ALARM_MAX     = 3'd1,
        CFG_ALARM_MIN     = 3'd2,
        CFG_CHANGE_HOLD   = 3'd3,
        CFG_ON_DELAY      = 3'd4,
        CFG_OFF_DELAY     = 3'd5,
        CFG_SETPOINTS     = 3'd6,
        CFG_HYSTERESIS    = 3'd7
    } cfg_index_t;

endpackage

/* hw/rtl/staged_heater_controller_unit.sv */
// Staged heater controller: delay counter, mode machine and four relay stages.
//
// Input channel: in_valid / in_stall with heater_temp and safety_temp, one
// control tick per transfer. Output channel: out_valid / out_stall with
// relay_mask, control_mode, alarm_request and sensor_enable, one result per
// tick, in order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while no tick is in flight.
// Path: a tick is captured in the input register, processed by the stage and
// mode logic, and its result is captured in the result register. Throughput is
// one tick per cycle while the result is not held by out_stall.
// Reset clears all registers to zero, the mode to running and sets the
// sensor enable. While out_stall holds a result, the input register still
// takes one more tick; in_stall rises only when both registers are full.
module staged_heater_controller_unit
    import shc_pkg::*;
#(
    parameter int TEMP_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [TEMP_WIDTH-1:0] heater_temp,
    input  logic signed [TEMP_WIDTH-1:0] safety_temp,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [NUM_STAGES-1:0]        relay_mask,
    output logic [1:0]                   control_mode,
    output logic                         alarm_request,
    output logic                         sensor_enable,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_WIDTH-1:0]         cfg_data
);

    localparam int CW = ((TEMP_WIDTH > LANE_WIDTH + 1) ? TEMP_WIDTH : LANE_WIDTH + 1) + 1;

    typedef enum logic [1:0] {
        MODE_RUN    = 2'd0,
        MODE_CHANGE = 2'd1,
        MODE_ALARM  = 2'd2,
        MODE_OFF    = 2'd3
    } mode_t;

    localparam logic signed [CW-1:0]          SAFETY_LIM = CW'(SAFETY_LIMIT);
    localparam logic [FAULT_WIDTH-1:0]        FAULT_LIM  = FAULT_WIDTH'(FAULT_LIMIT);
    localparam logic [NUM_STAGES-1:0]         ALARM_MASK = NUM_STAGES'(1) << (NUM_STAGES - 1);

    logic [1:0]                   alarm_en_reg;
    logic signed [TEMP_WIDTH-1:0] alarm_max_reg;
    logic signed [TEMP_WIDTH-1:0] alarm_min_reg;
    logic                         change_hold_reg;
    logic [DELAY_WIDTH-1:0]       on_delay_reg;
    logic [DELAY_WIDTH-1:0]       off_delay_reg;
    logic [CFG_WIDTH-1:0]         setpoints_reg;
    logic [CFG_WIDTH-1:0]         hysteresis_reg;

    logic                         s1_valid_reg;
    logic signed [TEMP_WIDTH-1:0] s1_heater_reg;
    logic signed [TEMP_WIDTH-1:0] s1_safety_reg;

    mode_t                        mode_reg, mode_next;
    logic [NUM_STAGES-1:0]        stage_on_reg, stage_on_next;
    logic [DELAY_WIDTH-1:0]       delay_count_reg, delay_count_next;
    logic                         delay_active_reg, delay_active_next;
    logic                         timer_done_reg, timer_done_next;
    logic [FAULT_WIDTH-1:0]       fault_count_reg, fault_count_next;
    logic                         alarm_on_reg, alarm_on_next;
    logic                         sensor_on_reg, sensor_on_next;

    logic                         out_valid_reg;
    logic [NUM_STAGES-1:0]        out_mask_reg;
    mode_t                        out_mode_reg;
    logic                         out_alarm_reg;
    logic                         out_sensor_reg;

    logic                         advance;
    logic signed [CW-1:0]         h_ext;
    logic signed [CW-1:0]         s_ext;
    logic signed [CW-1:0]         sp_ext;
    logic signed [CW-1:0]         low_ext;
    logic [LANE_WIDTH-1:0]        sp_lane;
    logic [LANE_WIDTH-1:0]        hy_lane;
    logic [FAULT_WIDTH-1:0]       fault_inc;
    logic                         hot;
    logic                         sensor_fault;
    logic                         max_en;
    logic                         min_en;
    logic                         alarm_hit;
    logic                         alarm_clear;
    logic                         want;
    logic [DELAY_WIDTH-1:0]       delay_sel;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;

    assign out_valid     = out_valid_reg;
    assign relay_mask    = out_mask_reg;
    assign control_mode  = out_mode_reg;
    assign alarm_request = out_alarm_reg;
    assign sensor_enable = out_sensor_reg;

    assign h_ext = {{(CW-TEMP_WIDTH){s1_heater_reg[TEMP_WIDTH-1]}}, s1_heater_reg};
    assign s_ext = {{(CW-TEMP_WIDTH){s1_safety_reg[TEMP_WIDTH-1]}}, s1_safety_reg};

    assign max_en    = alarm_en_reg[0];
    assign min_en    = alarm_en_reg[1];
    assign fault_inc = fault_count_reg + FAULT_WIDTH'(1);
    assign hot       = s_ext > SAFETY_LIM;

    assign alarm_hit = (max_en && (s1_heater_reg > alarm_max_reg))
                    || (min_en && (s1_heater_reg < alarm_min_reg));
    assign alarm_clear = (max_en && (s1_heater_reg < alarm_max_reg))
                      || (min_en && (s1_heater_reg > alarm_min_reg))
                      || (!min_en && (s1_heater_reg <= alarm_min_reg))
                      || (!max_en && (s1_heater_reg >= alarm_max_reg));

    always_comb
    begin
        mode_next         = mode_reg;
        stage_on_next     = stage_on_reg;
        delay_count_next  = delay_count_reg;
        delay_active_next = delay_active_reg;
        timer_done_next   = timer_done_reg;
        fault_count_next  = fault_count_reg;
        alarm_on_next     = alarm_on_reg;
        sensor_on_next    = sensor_on_reg;
        sensor_fault      = 1'b0;
        sp_lane           = '0;
        hy_lane           = '0;
        sp_ext            = '0;
        low_ext           = '0;
        want              = 1'b0;
        delay_sel         = '0;

        // advance the stage 1 delay
        if (delay_active_reg)
        begin
            if (delay_count_reg == '0)
            begin
                timer_done_next   = 1'b1;
                delay_active_next = 1'b0;
            end
            else
            begin
                delay_count_next = delay_count_reg - DELAY_WIDTH'(1);
            end
        end

        // sensor check, used in running and alarm modes
        if (mode_reg == MODE_RUN || mode_reg == MODE_ALARM)
        begin
            if (hot)
            begin
                if (fault_inc >= FAULT_LIM)
                begin
                    fault_count_next = '0;
                    sensor_fault     = 1'b1;
                end
                else
                begin
                    fault_count_next = fault_inc;
                end
            end
            else
            begin
                fault_count_next = '0;
            end
        end

        case (mode_reg)
            MODE_RUN:
            begin
                if (sensor_fault)
                begin
                    mode_next      = MODE_CHANGE;
                    sensor_on_next = 1'b0;
                end
                if (alarm_hit)
                begin
                    mode_next     = MODE_ALARM;
                    alarm_on_next = 1'b1;
                end
            end
            MODE_CHANGE:
            begin
                if (!change_hold_reg)
                begin
                    mode_next      = MODE_RUN;
                    sensor_on_next = 1'b1;
                end
            end
            MODE_ALARM:
            begin
                if (alarm_clear)
                begin
                    mode_next     = MODE_RUN;
                    alarm_on_next = 1'b0;
                end
                if (sensor_fault)
                begin
                    mode_next      = MODE_CHANGE;
                    sensor_on_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        case (mode_next)
            MODE_RUN:
            begin
                for (int i = 0; i < NUM_STAGES; i++)
                begin
                    sp_lane = setpoints_reg[i*LANE_WIDTH +: LANE_WIDTH];
                    hy_lane = hysteresis_reg[i*LANE_WIDTH +: LANE_WIDTH];
                    sp_ext  = {{(CW-LANE_WIDTH){1'b0}}, sp_lane};
                    low_ext = sp_ext - {{(CW-LANE_WIDTH){1'b0}}, hy_lane};
                    want    = stage_on_reg[i] ? (h_ext > sp_ext) : (h_ext < low_ext);
                    if (sp_lane == '0)
                    begin
                        stage_on_next[i] = 1'b0;
                    end
                    else if (want)
                    begin
                        if (i == 0)
                        begin
                            delay_sel = stage_on_reg[i] ? off_delay_reg : on_delay_reg;
                            if (delay_sel == '0)
                            begin
                                timer_done_next = 1'b1;
                            end
                            else
                            begin
                                delay_count_next  = delay_sel - DELAY_WIDTH'(1);
                                delay_active_next = 1'b1;
                            end
                            stage_on_next[i] = !stage_on_reg[i];
                        end
                        else if (i == 1)
                        begin
                            if (timer_done_next)
                            begin
                                timer_done_next  = 1'b0;
                                stage_on_next[i] = !stage_on_reg[i];
                            end
                        end
                        else
                        begin
                            stage_on_next[i] = !stage_on_reg[i];
                        end
                    end
                end
            end
            MODE_ALARM:
            begin
                stage_on_next = ALARM_MASK;
            end
            default:
            begin
                stage_on_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_en_reg     <= '0;
            alarm_max_reg    <= '0;
            alarm_min_reg    <= '0;
            change_hold_reg  <= 1'b0;
            on_delay_reg     <= '0;
            off_delay_reg    <= '0;
            setpoints_reg    <= '0;
            hysteresis_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            s1_heater_reg    <= '0;
            s1_safety_reg    <= '0;
            mode_reg         <= MODE_RUN;
            stage_on_reg     <= '0;
            delay_count_reg  <= '0;
            delay_active_reg <= 1'b0;
            timer_done_reg   <= 1'b0;
            fault_count_reg  <= '0;
            alarm_on_reg     <= 1'b0;
            sensor_on_reg    <= 1'b1;
            out_valid_reg    <= 1'b0;
            out_mask_reg     <= '0;
            out_mode_reg     <= MODE_RUN;
            out_alarm_reg    <= 1'b0;
            out_sensor_reg   <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_ALARM_ENABLES: alarm_en_reg    <= cfg_data[1:0];
                    CFG_ALARM_MAX:     alarm_max_reg   <= cfg_data[TEMP_WIDTH-1:0];
                    CFG_ALARM_MIN:     alarm_min_reg   <= cfg_data[TEMP_WIDTH-1:0];
                    CFG_CHANGE_HOLD:   change_hold_reg <= cfg_data[0];
                    CFG_ON_DELAY:      on_delay_reg    <= cfg_data[DELAY_WIDTH-1:0];
                    CFG_OFF_DELAY:     off_delay_reg   <= cfg_data[DELAY_WIDTH-1:0];
                    CFG_SETPOINTS:     setpoints_reg   <= cfg_data;
                    CFG_HYSTERESIS:    hysteresis_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // take a new tick whenever the input register is free or draining
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
                if (in_valid)
                begin
                    s1_heater_reg <= heater_temp;
                    s1_safety_reg <= safety_temp;
                end
            end

            if (advance)
            begin
                mode_reg         <= mode_next;
                stage_on_reg     <= stage_on_next;
                delay_count_reg  <= delay_count_next;
                delay_active_reg <= delay_active_next;
                timer_done_reg   <= timer_done_next;
                fault_count_reg  <= fault_count_next;
                alarm_on_reg     <= alarm_on_next;
                sensor_on_reg    <= sensor_on_next;
                out_valid_reg    <= 1'b1;
                out_mask_reg     <= stage_on_next;
                out_mode_reg     <= mode_next;
                out_alarm_reg    <= alarm_on_next;
                out_sensor_reg   <= sensor_on_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_mode_never_off: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_OFF)
        else $error("mode machine entered off mode");

    a_fault_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        fault_count_reg < FAULT_LIM)
        else $error("fault count reached the fault limit without clearing");

    a_alarm_relays: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_mode_reg == MODE_ALARM |-> out_mask_reg == ALARM_MASK)
        else $error("alarm result does not drive only the last stage");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with a free register");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_mask_reg))
        else $error("stalled result was dropped or changed");
`endif

endmodule

/* verif/tb_staged_heater_controller_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the staged heater controller: predicted relay results versus the DUT.
module tb_staged_heater_controller_unit;
    import shc_pkg::*;

    localparam int TEMP_W          = 16;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int RANDOM_PHASES   = 6;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int QUIET_LIMIT     = 4000;
    localparam int TAIL_CYCLES     = 8;

    typedef enum logic [1:0] {
        MODE_RUNNING       = 2'd0,
        MODE_SENSOR_CHANGE = 2'd1,
        MODE_ALARM         = 2'd2,
        MODE_OFF           = 2'd3
    } ctrl_mode_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] relays;
        ctrl_mode_t            mode;
        logic                  alarm;
        logic                  sensor;
    } relay_result_t;

    class relay_scoreboard;
        logic [1:0]             alarm_enables;
        int                     alarm_max;
        int                     alarm_min;
        logic                   change_hold;
        logic [DELAY_WIDTH-1:0] on_delay;
        logic [DELAY_WIDTH-1:0] off_delay;
        logic [CFG_WIDTH-1:0]   setpoints;
        logic [CFG_WIDTH-1:0]   hysteresis;

        ctrl_mode_t             mode;
        logic [NUM_STAGES-1:0]  stage_on;
        logic [DELAY_WIDTH-1:0] delay_count;
        logic                   delay_active;
        logic                   timer_done;
        logic [FAULT_WIDTH-1:0] fault_count;
        logic                   alarm_on;
        logic                   sensor_on;

        relay_result_t pending_relay_results[$];
        int unsigned   mismatches;
        int unsigned   results_checked;
        int unsigned   alarm_ticks;
        int unsigned   change_ticks;

        function new();
            alarm_enables   = '0;
            alarm_max       = 0;
            alarm_min       = 0;
            change_hold     = 1'b0;
            on_delay        = '0;
            off_delay       = '0;
            setpoints       = '0;
            hysteresis      = '0;
            mode            = MODE_RUNNING;
            stage_on        = '0;
            delay_count     = '0;
            delay_active    = 1'b0;
            timer_done      = 1'b0;
            fault_count     = '0;
            alarm_on        = 1'b0;
            sensor_on       = 1'b1;
            mismatches      = 0;
            results_checked = 0;
            alarm_ticks     = 0;
            change_ticks    = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_WIDTH-1:0] data);
            case (idx)
                CFG_ALARM_ENABLES: alarm_enables = data[1:0];
                CFG_ALARM_MAX:     alarm_max     = $signed(data[TEMP_W-1:0]);
                CFG_ALARM_MIN:     alarm_min     = $signed(data[TEMP_W-1:0]);
                CFG_CHANGE_HOLD:   change_hold   = data[0];
                CFG_ON_DELAY:      on_delay      = data[DELAY_WIDTH-1:0];
                CFG_OFF_DELAY:     off_delay     = data[DELAY_WIDTH-1:0];
                CFG_SETPOINTS:     setpoints     = data;
                CFG_HYSTERESIS:    hysteresis    = data;
                default: ;
            endcase
        endfunction

        function bit sensor_fault(int safety);
            if (safety > SAFETY_LIMIT) begin
                fault_count = fault_count + 1'b1;
                if (fault_count >= FAULT_LIMIT) begin
                    fault_count = '0;
                    return 1'b1;
                end
            end
            else
                fault_count = '0;
            return 1'b0;
        endfunction

        function void start_delay(logic [DELAY_WIDTH-1:0] d);
            if (d == '0)
                timer_done = 1'b1;
            else begin
                delay_count  = d - 1'b1;
                delay_active = 1'b1;
            end
        endfunction

        function void step_stage(int i, int heat);
            int sp;
            int hy;
            bit on;
            bit want;
            sp   = int'(setpoints[LANE_WIDTH*i +: LANE_WIDTH]);
            hy   = int'(hysteresis[LANE_WIDTH*i +: LANE_WIDTH]);
            on   = stage_on[i];
            want = on ? (heat > sp) : (heat < sp - hy);
            if (!want)
                return;
            if (i == 1) begin
                if (!timer_done)
                    return;
                timer_done = 1'b0;
            end
            else if (i == 0)
                start_delay(on ? off_delay : on_delay);
            stage_on[i] = ~stage_on[i];
        endfunction

        function void accept_tick(logic signed [TEMP_W-1:0] heater,
                                  logic signed [TEMP_W-1:0] safety);
            int heat;
            int safe;
            bit max_en;
            bit min_en;
            relay_result_t r;
            heat   = heater;
            safe   = safety;
            max_en = alarm_enables[0];
            min_en = alarm_enables[1];

            if (delay_active) begin
                if (delay_count == '0) begin
                    timer_done   = 1'b1;
                    delay_active = 1'b0;
                end
                else
                    delay_count = delay_count - 1'b1;
            end

            case (mode)
                MODE_RUNNING: begin
                    if (sensor_fault(safe)) begin
                        mode      = MODE_SENSOR_CHANGE;
                        sensor_on = 1'b0;
                    end
                    if ((max_en && heat > alarm_max) || (min_en && heat < alarm_min)) begin
                        mode     = MODE_ALARM;
                        alarm_on = 1'b1;
                    end
                end
                MODE_SENSOR_CHANGE: begin
                    if (!change_hold) begin
                        mode      = MODE_RUNNING;
                        sensor_on = 1'b1;
                    end
                end
                MODE_ALARM: begin
                    if ((max_en && heat < alarm_max) || (min_en && heat > alarm_min) ||
                        (!min_en && heat <= alarm_min) || (!max_en && heat >= alarm_max)) begin
                        mode     = MODE_RUNNING;
                        alarm_on = 1'b0;
                    end
                    if (sensor_fault(safe)) begin
                        mode      = MODE_SENSOR_CHANGE;
                        sensor_on = 1'b0;
                    end
                end
                default: ;
            endcase

            case (mode)
                MODE_RUNNING: begin
                    for (int i = 0; i < NUM_STAGES; i++) begin
                        if (setpoints[LANE_WIDTH*i +: LANE_WIDTH] != '0)
                            step_stage(i, heat);
                        else
                            stage_on[i] = 1'b0;
                    end
                end
                MODE_ALARM: stage_on = 4'b1000;
                default:    stage_on = '0;
            endcase

            if (mode == MODE_ALARM)
                alarm_ticks++;
            if (mode == MODE_SENSOR_CHANGE)
                change_ticks++;
            r.relays = stage_on;
            r.mode   = mode;
            r.alarm  = alarm_on;
            r.sensor = sensor_on;
            pending_relay_results.push_back(r);
        endfunction

        function void check_relay_result(logic [NUM_STAGES-1:0] relays, logic [1:0] mode_code,
                                         logic alarm, logic sensor);
            relay_result_t e;
            if (pending_relay_results.size() == 0) begin
                $error("result transfer with no pending tick");
                mismatches++;
                return;
            end
            e = pending_relay_results.pop_front();
            results_checked++;
            if (relays !== e.relays) begin
                $error("relay_mask expected %h actual %h", e.relays, relays);
                mismatches++;
            end
            if (mode_code !== e.mode) begin
                $error("control_mode expected %0d actual %0d", e.mode, mode_code);
                mismatches++;
            end
            if (alarm !== e.alarm) begin
                $error("alarm_request expected %b actual %b", e.alarm, alarm);
                mismatches++;
            end
            if (sensor !== e.sensor) begin
                $error("sensor_enable expected %b actual %b", e.sensor, sensor);
                mismatches++;
            end
        endfunction

        function void flag_missing_results();
            if (pending_relay_results.size() != 0) begin
                $error("%0d results never arrived", pending_relay_results.size());
                mismatches += pending_relay_results.size();
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_stall;
    logic signed [TEMP_W-1:0] heater_temp   = '0;
    logic signed [TEMP_W-1:0] safety_temp   = '0;
    logic                     out_valid;
    logic                     out_stall     = 1'b0;
    logic [NUM_STAGES-1:0]    relay_mask;
    logic [1:0]               control_mode;
    logic                     alarm_request;
    logic                     sensor_enable;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index     = '0;
    logic [CFG_WIDTH-1:0]     cfg_data      = '0;

    logic [CFG_WIDTH-1:0] reg_image [8];
    int unsigned          send_idle_pct = 31;
    int unsigned          recv_idle_pct = 87;
    int unsigned          hold_requests = 0;
    int unsigned          holds_served  = 0;
    relay_scoreboard      sb = new();

    staged_heater_controller_unit #(.TEMP_WIDTH(TEMP_W)) DUT (.*);

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_tick(input logic signed [TEMP_W-1:0] h,
                             input logic signed [TEMP_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        heater_temp <= h;
        safety_temp <= s;
        do @(posedge clk); while (in_stall);
        sb.accept_tick(h, s);
    endtask

    task automatic program_registers();
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= reg_image[i];
            do @(posedge clk); while (!cfg_ready);
            sb.set_register(cfg_index_t'(i), reg_image[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain(input int tail);
        in_valid <= 1'b0;
        while (sb.pending_relay_results.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_relay_result(relay_mask, control_mode, alarm_request, sensor_enable);
            if (hold_left == 0 && holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int directed_heat [25] = '{100, 100, 100, 100, 250, 300, 301, 32767, 0, 0, 0, -100,
                                   -101, -32768, 32767, -32768, 400, 400, 400, 400, 400,
                                   0, 0, 195, 185};
        int directed_safe [25] = '{0, 0, 0, 0, 5000, 5001, 5001, 5001, 32767, 32767, 32767,
                                   -32768, 0, 0, -1, 32767, 6000, 6000, 6000, 6000, 6000,
                                   21845, -21846, 0, 0};
        int burst_left;
        int centre;
        int hv;
        int sv;
        int unsigned pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_image[CFG_ALARM_ENABLES] = 64'd3;
        reg_image[CFG_ALARM_MAX]     = 64'd300;
        reg_image[CFG_ALARM_MIN]     = 64'(-100);
        reg_image[CFG_CHANGE_HOLD]   = 64'd0;
        reg_image[CFG_ON_DELAY]      = 64'd2;
        reg_image[CFG_OFF_DELAY]     = 64'd0;
        reg_image[CFG_SETPOINTS]     = {16'd260, 16'd240, 16'd220, 16'd200};
        reg_image[CFG_HYSTERESIS]    = {16'd5, 16'd0, 16'd20, 16'd10};
        program_registers();
        for (int i = 0; i < 25; i++)
            send_tick(TEMP_W'(directed_heat[i]), TEMP_W'(directed_safe[i]));
        drain(0);

        burst_left = 0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            send_idle_pct = (p < 2) ? 31 : (p < 4) ? 87 : 0;
            recv_idle_pct = (p < 2) ? 87 : (p < 4) ? 31 : 0;

            for (int r = 0; r < 8; r++)
                reg_image[r] = {$urandom, $urandom};
            case (p)
                1: begin
                    reg_image[CFG_ALARM_ENABLES][1:0]  = 2'd3;
                    reg_image[CFG_ALARM_MAX][15:0]     = 16'h7FFF;
                    reg_image[CFG_ALARM_MIN][15:0]     = 16'h8000;
                    reg_image[CFG_CHANGE_HOLD][0]      = 1'b0;
                    reg_image[CFG_ON_DELAY][15:0]      = 16'hFFFF;
                    reg_image[CFG_OFF_DELAY][15:0]     = 16'hFFFF;
                    reg_image[CFG_SETPOINTS]           = '1;
                    reg_image[CFG_HYSTERESIS]          = '1;
                end
                5: begin
                    reg_image[CFG_ALARM_ENABLES][1:0]  = 2'd0;
                    reg_image[CFG_ALARM_MAX][15:0]     = 16'h8000;
                    reg_image[CFG_ALARM_MIN][15:0]     = 16'h7FFF;
                    reg_image[CFG_CHANGE_HOLD][0]      = 1'b0;
                    reg_image[CFG_ON_DELAY][15:0]      = 16'h0000;
                    reg_image[CFG_OFF_DELAY][15:0]     = 16'h0000;
                    reg_image[CFG_HYSTERESIS]          = '0;
                    for (int l = 0; l < NUM_STAGES; l++)
                        reg_image[CFG_SETPOINTS][16*l +: 16] = 16'($urandom_range(900));
                end
                default: begin
                    reg_image[CFG_ALARM_ENABLES][1:0]  = 2'($urandom_range(3));
                    reg_image[CFG_ALARM_MAX][15:0]     = 16'(200 + $urandom_range(800));
                    reg_image[CFG_ALARM_MIN][15:0]     = 16'(-int'($urandom_range(500)));
                    reg_image[CFG_CHANGE_HOLD][0]      = (p == 3);
                    reg_image[CFG_ON_DELAY][15:0]      = 16'($urandom_range(4));
                    reg_image[CFG_OFF_DELAY][15:0]     = 16'($urandom_range(4));
                    for (int l = 0; l < NUM_STAGES; l++) begin
                        reg_image[CFG_SETPOINTS][16*l +: 16] =
                            ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(900, 1));
                        reg_image[CFG_HYSTERESIS][16*l +: 16] = 16'($urandom_range(60));
                    end
                end
            endcase
            program_registers();

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 4 && n == 100)
                    hold_requests++;

                pick = $urandom_range(7);
                if (pick < NUM_STAGES)
                    centre = int'(reg_image[CFG_SETPOINTS][16*pick +: 16]);
                else if (pick == 4)
                    centre = int'($signed(reg_image[CFG_ALARM_MAX][15:0]));
                else if (pick == 5)
                    centre = int'($signed(reg_image[CFG_ALARM_MIN][15:0]));
                else
                    centre = 0;
                hv = (pick == 7) ? int'($urandom) : centre + int'($urandom_range(80)) - 40;

                if (burst_left > 0) begin
                    sv = 5001 + int'($urandom_range(27766));
                    burst_left--;
                end
                else if ($urandom_range(99) < 4) begin
                    sv = 5001 + int'($urandom_range(27766));
                    burst_left = $urandom_range(6, 4);
                end
                else begin
                    case ($urandom_range(9))
                        0, 1:    sv = int'($urandom);
                        2, 3:    sv = 4995 + int'($urandom_range(10));
                        default: sv = int'($urandom_range(5000)) - 200;
                    endcase
                end
                send_tick(TEMP_W'(hv), TEMP_W'(sv));
            end
            drain((p == RANDOM_PHASES - 1) ? TAIL_CYCLES : 0);
        end

        sb.flag_missing_results();
        $display("Checked %0d control ticks over %0d register settings with one %0d-cycle output hold-off",
                 sb.results_checked, RANDOM_PHASES + 1, HOLD_OFF_CYCLES);
        $display("Alarm mode expected on %0d ticks, sensor change on %0d ticks",
                 sb.alarm_ticks, sb.change_ticks);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
